// ===== hw/rtl/g23etd_pkg.sv =====
// Shared types, constants and syndrome table for the Golay (23,12) error trapping decoder.
package g23etd_pkg;

    localparam int unsigned WORD_W   = 23;
    localparam int unsigned PAR_W    = 11;
    localparam int unsigned DATA_W   = 12;
    localparam int unsigned CNT_W    = 5;
    localparam int unsigned WGT_W    = 4;
    localparam logic [CNT_W-1:0] LAST_STEP  = CNT_W'(WORD_W - 1);
    localparam logic [WGT_W-1:0] FIRST_LIMIT = WGT_W'(3);
    localparam logic [WGT_W-1:0] RETRY_LIMIT = WGT_W'(2);

    // Syndrome contribution of each data bit, indexed by bit position minus 11.
    localparam logic [PAR_W-1:0] DATA_ROWS [DATA_W] = '{
        11'h2e3, 11'h5c6, 11'h16f, 11'h2de, 11'h5bc, 11'h19b,
        11'h336, 11'h66c, 11'h63b, 11'h695, 11'h7c9, 11'h571
    };

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic [PAR_W-1:0] syndrome;
        logic             hit;
    } t_trial;

endpackage

// ===== hw/rtl/g23etd_trial.sv =====
// Shared trial unit: syndrome of one rotation and weight test against the pass limit.
module g23etd_trial (
    input  logic [g23etd_pkg::WORD_W-1:0] i_word,
    input  logic                          i_retry,
    output g23etd_pkg::t_trial            o_trial
);

    logic [g23etd_pkg::PAR_W-1:0] w_syn;
    logic [g23etd_pkg::WGT_W-1:0] w_wgt;
    logic [g23etd_pkg::WGT_W-1:0] w_limit;

    always_comb begin
        w_syn = i_word[g23etd_pkg::PAR_W-1:0];
        for (int k = 0; k < g23etd_pkg::DATA_W; k++) begin
            if (i_word[g23etd_pkg::PAR_W + k]) begin
                w_syn = w_syn ^ g23etd_pkg::DATA_ROWS[k];
            end
        end
    end

    always_comb begin
        w_wgt = '0;
        for (int k = 0; k < g23etd_pkg::PAR_W; k++) begin
            w_wgt = w_wgt + g23etd_pkg::WGT_W'(w_syn[k]);
        end
    end

    assign w_limit          = i_retry ? g23etd_pkg::RETRY_LIMIT : g23etd_pkg::FIRST_LIMIT;
    assign o_trial.syndrome = w_syn;
    assign o_trial.hit      = (w_wgt <= w_limit);

endmodule

// ===== hw/rtl/golay23_error_trapping_decoder.sv =====
// Golay (23,12) error trapping decoder: one trial rotation per cycle under a small sequencer,
// unless a stalled result holds the final trial; the trials run as passes of rotations, each a
// syndrome and weight test in the shared trial unit, and the result is registered.
// A new word is taken only in idle, so o_ready is low while a word is in work,
// and a stalled result holds the final trial until the output register frees up.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and clears o_valid.
module golay23_error_trapping_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [g23etd_pkg::WORD_W-1:0] i_received_word,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [g23etd_pkg::WORD_W-1:0] o_corrected_word,
    output logic [g23etd_pkg::DATA_W-1:0] o_data_bits,
    output logic                          o_failed
);

    localparam int unsigned W = g23etd_pkg::WORD_W;

    g23etd_pkg::t_state         r_state, n_state;
    logic [W-1:0]               r_rx, n_rx;
    logic [W-1:0]               r_word, n_word;
    logic [g23etd_pkg::CNT_W-1:0] r_pass, n_pass;
    logic [g23etd_pkg::CNT_W-1:0] r_rot, n_rot;
    logic                       r_valid, n_valid;
    logic [W-1:0]               r_cw, n_cw;
    logic                       r_fail, n_fail;

    g23etd_pkg::t_trial         w_trial;
    logic                       w_take;
    logic                       w_out_free;
    logic                       w_last_rot;
    logic                       w_fail_now;
    logic                       w_done;
    logic [W-1:0]               w_fixed;
    logic [2*W-1:0]             w_dbl;

    g23etd_trial u_trial (
        .i_word  (r_word),
        .i_retry (r_pass != '0),
        .o_trial (w_trial)
    );

    assign w_take     = i_valid && (r_state == g23etd_pkg::ST_IDLE);
    assign w_out_free = !r_valid || i_ready;
    assign w_last_rot = (r_rot == g23etd_pkg::LAST_STEP);
    assign w_fail_now = !w_trial.hit && w_last_rot && (r_pass == g23etd_pkg::LAST_STEP);
    assign w_done     = (r_state == g23etd_pkg::ST_RUN) && (w_trial.hit || w_fail_now)
                        && w_out_free;

    // Rotate the trapped word back left by the rotation count.
    assign w_dbl   = {r_word ^ {{(W - g23etd_pkg::PAR_W){1'b0}}, w_trial.syndrome},
                      r_word ^ {{(W - g23etd_pkg::PAR_W){1'b0}}, w_trial.syndrome}} << r_rot;
    assign w_fixed = w_dbl[2*W-1:W];

    always_comb begin
        n_state = r_state;
        case (r_state)
            g23etd_pkg::ST_IDLE: begin
                if (w_take) begin
                    n_state = g23etd_pkg::ST_RUN;
                end
            end
            g23etd_pkg::ST_RUN: begin
                if (w_done) begin
                    n_state = g23etd_pkg::ST_IDLE;
                end
            end
            default: n_state = g23etd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_rx    = r_rx;
        n_word  = r_word;
        n_pass  = r_pass;
        n_rot   = r_rot;
        n_valid = r_valid && !i_ready;
        n_cw    = r_cw;
        n_fail  = r_fail;
        case (r_state)
            g23etd_pkg::ST_IDLE: begin
                if (w_take) begin
                    n_rx   = i_received_word;
                    n_word = i_received_word;
                    n_pass = '0;
                    n_rot  = '0;
                end
            end
            g23etd_pkg::ST_RUN: begin
                if (w_trial.hit || w_fail_now) begin
                    // hold the trial until the output register frees up
                    if (w_out_free) begin
                        n_valid = 1'b1;
                        n_fail  = !w_trial.hit;
                        n_cw    = w_trial.hit ? w_fixed : '0;
                    end
                end else if (w_last_rot) begin
                    // next pass: flip bit (pass - 1) of the received word
                    n_pass = r_pass + 1'b1;
                    n_rot  = '0;
                    n_word = r_rx ^ (W'(1) << r_pass);
                end else begin
                    n_rot  = r_rot + 1'b1;
                    n_word = {r_word[0], r_word[W-1:1]};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= g23etd_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx   <= n_rx;
        r_word <= n_word;
        r_pass <= n_pass;
        r_rot  <= n_rot;
        r_cw   <= n_cw;
        r_fail <= n_fail;
    end

    assign o_ready          = (r_state == g23etd_pkg::ST_IDLE);
    assign o_valid          = r_valid;
    assign o_corrected_word = r_cw;
    assign o_data_bits      = r_cw[W-1:g23etd_pkg::PAR_W];
    assign o_failed         = r_fail;

endmodule

// ===== hw/rtl/g23etd_checker.sv =====
// Port-level checks for the Golay (23,12) error trapping decoder, bound to the top level.
module g23etd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [g23etd_pkg::WORD_W-1:0] o_corrected_word,
    input logic [g23etd_pkg::DATA_W-1:0] o_data_bits,
    input logic                          o_failed
);

    // a failed result carries an all-zero word
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_failed |-> (o_corrected_word == '0) && (o_data_bits == '0))
        else $error("failed result with nonzero word");

    a_data_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data_bits == o_corrected_word[g23etd_pkg::WORD_W-1:g23etd_pkg::PAR_W])
        else $error("data bits do not match corrected word");

    // a word in work blocks the input side
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input ready right after a transfer");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_corrected_word) && $stable(o_failed))
        else $error("stalled result changed");

endmodule

bind golay23_error_trapping_decoder g23etd_checker u_g23etd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_corrected_word (o_corrected_word),
    .o_data_bits      (o_data_bits),
    .o_failed         (o_failed)
);
